/* src/ctssf_pkg.sv */
`timescale 1ns / 1ps
package ctssf_pkg;

  localparam int BinW            = 20;
  localparam int CntW            = 14;
  localparam int CntBcdW         = 20;
  localparam int ValBcdW         = 28;
  localparam int DdStages        = 4;
  localparam int DdItersPerStage = BinW / DdStages;
  localparam int InDataW         = 56;
  localparam int OutDataW        = 80;

  // both binaries are shifted msb first, count is zero padded to the value width
  typedef struct packed {
    logic [CntBcdW-1:0] cnt_bcd;
    logic [BinW-1:0]    cnt_bin;
    logic [ValBcdW-1:0] val_bcd;
    logic [BinW-1:0]    val_bin;
  } stage_t;

  typedef enum logic [1:0] {
    TAB_COUNT = 2'd0,
    TAB_VALUE = 2'd1,
    TAB_STD   = 2'd2
  } seg_tab_t;

  function automatic logic [7:0] seg_lookup(input seg_tab_t tab, input logic [3:0] dig);
    logic [7:0] seg;
    seg = 8'h00;
    case (tab)
      TAB_COUNT: begin
        case (dig)
          4'd0: seg = 8'hfc;
          4'd1: seg = 8'h84;
          4'd2: seg = 8'hba;
          4'd3: seg = 8'hae;
          4'd4: seg = 8'hc6;
          4'd5: seg = 8'h6e;
          4'd6: seg = 8'h7e;
          4'd7: seg = 8'ha4;
          4'd8: seg = 8'hfe;
          4'd9: seg = 8'hee;
          default: seg = 8'h00;
        endcase
      end
      TAB_VALUE: begin
        case (dig)
          4'd0: seg = 8'h3f;
          4'd1: seg = 8'h24;
          4'd2: seg = 8'h5d;
          4'd3: seg = 8'h75;
          4'd4: seg = 8'h66;
          4'd5: seg = 8'h73;
          4'd6: seg = 8'h7b;
          4'd7: seg = 8'h25;
          4'd8: seg = 8'h7f;
          4'd9: seg = 8'h77;
          default: seg = 8'h00;
        endcase
      end
      TAB_STD: begin
        case (dig)
          4'd0: seg = 8'h3f;
          4'd1: seg = 8'h06;
          4'd2: seg = 8'h5b;
          4'd3: seg = 8'h4f;
          4'd4: seg = 8'h66;
          4'd5: seg = 8'h6d;
          4'd6: seg = 8'h7d;
          4'd7: seg = 8'h07;
          4'd8: seg = 8'h7f;
          4'd9: seg = 8'h6f;
          default: seg = 8'h00;
        endcase
      end
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

/* src/ctssf_dabble_stage.sv */
`timescale 1ns / 1ps
module ctssf_dabble_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  ctssf_pkg::stage_t in_data,
  output logic            out_valid,
  output ctssf_pkg::stage_t out_data
);
  import ctssf_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  // add 3 to every digit of 5 or more, then shift in one binary bit
  function automatic logic [ValBcdW-1:0] dd_iter(input logic [ValBcdW-1:0] bcd,
                                                 input logic b);
    logic [ValBcdW-1:0] adj;
    adj = bcd;
    for (int j = 0; j < ValBcdW / 4; j++) begin
      if (adj[4*j +: 4] >= 4'd5) begin
        adj[4*j +: 4] = adj[4*j +: 4] + 4'd3;
      end
    end
    return {adj[ValBcdW-2:0], b};
  endfunction

  always_comb begin
    logic [ValBcdW-1:0] cb;
    data_nxt = in_data;
    cb = '0;
    for (int k = 0; k < DdItersPerStage; k++) begin
      cb = dd_iter({{(ValBcdW-CntBcdW){1'b0}}, data_nxt.cnt_bcd}, data_nxt.cnt_bin[BinW-1]);
      data_nxt.cnt_bcd = cb[CntBcdW-1:0];
      data_nxt.cnt_bin = {data_nxt.cnt_bin[BinW-2:0], 1'b0};
      data_nxt.val_bcd = dd_iter(data_nxt.val_bcd, data_nxt.val_bin[BinW-1]);
      data_nxt.val_bin = {data_nxt.val_bin[BinW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* src/count_total_seven_segment_formatter.sv */
`timescale 1ns / 1ps
// Count / total seven-segment formatter.
// Input stream (in_tvalid/in_tready/in_tdata/in_tuser) carries the piece count,
// the running total, the preset threshold and the show_total flag. Output stream
// (out_*) carries ten segment bytes per item, count group then value group.
// cfg_valid/cfg_ready/cfg_data writes the panel type; cfg_ready is always high.
// Write it only while no item is in flight.
// out_tvalid rises after the input transfer has passed four double-dabble
// stages of five shift iterations each, then the blanking and table stage that
// also serves as the output register. Throughput: one item per cycle while
// out_tready stays high.
// Reset clears all valid bits and sets panel type 0. When the receiver stalls,
// the output register holds and the stall propagates back stage by stage:
// in_tready drops only once every stage holds an item, nothing is dropped.
module count_total_seven_segment_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] piece_count, [33:14] running_total, [53:34] preset_threshold, [55:54] zero
  input  logic [ctssf_pkg::InDataW-1:0] in_tdata,
  // [0] show_total
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // bytes from low: count_seg_0..3, value_seg_0..5
  output logic [ctssf_pkg::OutDataW-1:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data
);
  import ctssf_pkg::*;

  logic                  panel_type_r;
  logic [DdStages:0]     stg_valid;
  stage_t                stg_data [DdStages+1];
  logic [DdStages+1:1]   stg_en;
  logic                  out_valid_r;
  logic [OutDataW-1:0]   out_data_r;
  logic [OutDataW-1:0]   out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_type_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      panel_type_r <= cfg_data[0];
    end
  end

  assign stg_valid[0]        = in_tvalid;
  assign stg_data[0].cnt_bcd = '0;
  assign stg_data[0].cnt_bin = {{(BinW-CntW){1'b0}}, in_tdata[CntW-1:0]};
  assign stg_data[0].val_bcd = '0;
  assign stg_data[0].val_bin = in_tuser[0] ? in_tdata[CntW+BinW-1:CntW]
                                           : in_tdata[CntW+2*BinW-1:CntW+BinW];

  assign stg_en[DdStages+1] = !out_valid_r || out_tready;
  assign in_tready          = stg_en[1];

  for (genvar k = 1; k <= DdStages; k++) begin : g_stage
    assign stg_en[k] = !stg_valid[k] || stg_en[k+1];
    ctssf_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (stg_en[k]),
      .in_valid (stg_valid[k-1]),
      .in_data  (stg_data[k-1]),
      .out_valid(stg_valid[k]),
      .out_data (stg_data[k])
    );
  end

  // digs[0] is the most significant position of the group
  function automatic logic [5:0][7:0] format_group(input logic [5:0][3:0] digs,
                                                   input logic [2:0] ndig,
                                                   input seg_tab_t tab);
    logic [5:0][7:0] segs;
    logic            leading;
    segs    = '0;
    leading = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < ndig) begin
        if (leading && digs[i] == 4'd0 && 3'(i) != ndig - 3'd1) begin
          segs[i] = 8'h00;
        end else begin
          leading = 1'b0;
          segs[i] = seg_lookup(tab, digs[i]);
        end
      end
    end
    return segs;
  endfunction

  always_comb begin
    logic [5:0][3:0] cdig;
    logic [5:0][3:0] vdig;
    logic [5:0][7:0] cseg;
    logic [5:0][7:0] vseg;
    logic [CntBcdW-1:0] cb;
    logic [ValBcdW-1:0] vb;
    cb   = stg_data[DdStages].cnt_bcd;
    vb   = stg_data[DdStages].val_bcd;
    cdig = '0;
    vdig = '0;
    if (!panel_type_r) begin
      for (int i = 0; i < 3; i++) cdig[i] = cb[4*(2-i) +: 4];
      for (int i = 0; i < 6; i++) vdig[i] = vb[4*(5-i) +: 4];
      cseg = format_group(cdig, 3'd3, TAB_COUNT);
      vseg = format_group(vdig, 3'd6, TAB_VALUE);
    end else begin
      for (int i = 0; i < 4; i++) cdig[i] = cb[4*(3-i) +: 4];
      for (int i = 0; i < 5; i++) vdig[i] = vb[4*(4-i) +: 4];
      cseg = format_group(cdig, 3'd4, TAB_STD);
      vseg = format_group(vdig, 3'd5, TAB_STD);
    end
    out_data_nxt = '0;
    for (int i = 0; i < 4; i++) out_data_nxt[8*i +: 8] = cseg[i];
    for (int i = 0; i < 6; i++) out_data_nxt[32 + 8*i +: 8] = vseg[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stg_en[DdStages+1]) begin
      out_valid_r <= stg_valid[DdStages];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[DdStages+1]) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted transfer always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> stg_valid[1])
    else $error("accepted item missing from first stage");

  // a stalled last stage keeps its item
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[DdStages] && !stg_en[DdStages] |=> stg_valid[DdStages])
    else $error("stalled item lost in last dabble stage");

  // the last digit of each group is never dark
  a_cnt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:16] != 8'h00 || out_tdata[31:24] != 8'h00)
    else $error("count group last digit blanked");

  a_val_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:64] != 8'h00 || out_tdata[79:72] != 8'h00)
    else $error("value group last digit blanked");

endmodule
